// File: src/calendar_date_difference_macros.svh
// assertion macros for the date difference block
`ifndef CALENDAR_DATE_DIFFERENCE_MACROS_SVH
`define CALENDAR_DATE_DIFFERENCE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date difference check failed");

// next-cycle implication, disabled in reset
`define CDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date difference check failed");

`endif

// File: src/cdd_pkg.sv
`default_nettype none

package cdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // calendar codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
  localparam logic [DAY_W-1:0]   DAY_MIN  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_FEB_SHORT = 5'd28;
  localparam logic [DAY_W-1:0]   DAY_FEB_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]   DAY_SHORT_MONTH = 5'd30;
  localparam logic [DAY_W-1:0]   DAY_LONG_MONTH  = 5'd31;

  // divisibility by 25 via the inverse of 25 modulo 2^14
  localparam logic [YEAR_W-1:0]  LEAP_INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0]  LEAP_DIV25_MAX = 14'd655;

  // cleaned date with its leap flag
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               leap;
  } date_t;

  // gregorian leap test: div by 4, and not by 100 unless by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, LEAP_INV25};
    div25 = (prod[YEAR_W-1:0] <= LEAP_DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // days in a month
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? DAY_FEB_LEAP : DAY_FEB_SHORT;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_SHORT_MONTH;
      default: len = DAY_LONG_MONTH;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: src/cdd_clean.sv
`default_nettype none

module cdd_clean
  import cdd_pkg::*;
(
  input  wire logic [YEAR_W-1:0]  year,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [DAY_W-1:0]   day,
  output date_t                   date
);

  logic [YEAR_W-1:0]  yy;
  logic [MONTH_W-1:0] mm;
  logic               leap;
  logic [DAY_W-1:0]   len;

  // clamp year and month into range
  always_comb begin
    if (year < YEAR_MIN) begin
      yy = YEAR_MIN;
    end else if (year > YEAR_MAX) begin
      yy = YEAR_MAX;
    end else begin
      yy = year;
    end
    if (month < MONTH_JAN) begin
      mm = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      mm = MONTH_DEC;
    end else begin
      mm = month;
    end
  end

  assign leap = is_leap(yy);
  assign len  = month_len(leap, mm);

  // clamp day to at least 1 and at most the month length
  always_comb begin
    date.year  = yy;
    date.month = mm;
    date.leap  = leap;
    if (day < DAY_MIN) begin
      date.day = DAY_MIN;
    end else if (day > len) begin
      date.day = len;
    end else begin
      date.day = day;
    end
  end

endmodule

`default_nettype wire

// File: src/cdd_diff.sv
`default_nettype none

module cdd_diff
  import cdd_pkg::*;
(
  input  wire date_t              date_a,
  input  wire date_t              date_b,
  output logic [YEAR_W-1:0]       years,
  output logic [MONTH_W-1:0]      months,
  output logic [DAY_W-1:0]        days
);

  logic               a_later;
  date_t              from_d;
  date_t              to_d;
  logic [DAY_W-1:0]   anchor;
  logic               day_borrow;
  logic               year_borrow;
  logic [MONTH_W-1:0] prev_month;
  logic [DAY_W-1:0]   prev_len;
  logic [DAY_W-1:0]   start_day;
  logic [MONTH_W-1:0] months_raw;

  // order the dates so the earlier one is the anchor
  assign a_later = (date_a.year != date_b.year)   ? (date_a.year > date_b.year) :
                   (date_a.month != date_b.month) ? (date_a.month > date_b.month) :
                                                    (date_a.day > date_b.day);
  assign from_d = a_later ? date_b : date_a;
  assign to_d   = a_later ? date_a : date_b;

  // feb 29 start counts as feb 28 in a common end year
  assign anchor = (from_d.month == MONTH_FEB && from_d.day == DAY_FEB_LEAP && !to_d.leap)
                  ? DAY_FEB_SHORT : from_d.day;

  assign day_borrow  = (to_d.day < anchor);
  assign year_borrow = (to_d.month < from_d.month) ||
                       ((to_d.month == from_d.month) && day_borrow);

  // whole years and months
  assign years = to_d.year - from_d.year - {{(YEAR_W-1){1'b0}}, year_borrow};
  assign months_raw = year_borrow ? (to_d.month + MONTH_DEC - from_d.month)
                                  : (to_d.month - from_d.month);
  assign months = months_raw - {{(MONTH_W-1){1'b0}}, day_borrow};

  // remaining days, counted within the month before the end date when a day is borrowed
  assign prev_month = (to_d.month == MONTH_JAN) ? MONTH_DEC : (to_d.month - 4'd1);
  assign prev_len   = month_len(to_d.leap, prev_month);
  assign start_day  = (anchor > prev_len) ? prev_len : anchor;
  assign days = day_borrow ? (prev_len - start_day + to_d.day) : (to_d.day - anchor);

endmodule

`default_nettype wire

// File: src/calendar_date_difference.sv
// calendar date difference: years, months and days between two dates
// throughput: one word per cycle; busy stays low outside reset
// the single pass is input register -> clean/compare/subtract -> result register
// reset (rst_n low, synchronous) drops pending words; busy is high while in reset
`default_nettype none

module calendar_date_difference
  import cdd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [YEAR_W-1:0]  in_first_year,
  input  wire logic [MONTH_W-1:0] in_first_month,
  input  wire logic [DAY_W-1:0]   in_first_day,
  input  wire logic [YEAR_W-1:0]  in_second_year,
  input  wire logic [MONTH_W-1:0] in_second_month,
  input  wire logic [DAY_W-1:0]   in_second_day,
  output logic                    out_valid,
  output logic [YEAR_W-1:0]       out_elapsed_years,
  output logic [MONTH_W-1:0]      out_elapsed_months,
  output logic [DAY_W-1:0]        out_elapsed_days
);

  logic               in_valid_r;
  logic [YEAR_W-1:0]  a_year_r;
  logic [MONTH_W-1:0] a_month_r;
  logic [DAY_W-1:0]   a_day_r;
  logic [YEAR_W-1:0]  b_year_r;
  logic [MONTH_W-1:0] b_month_r;
  logic [DAY_W-1:0]   b_day_r;

  date_t              date_a;
  date_t              date_b;
  logic [YEAR_W-1:0]  years_nxt;
  logic [MONTH_W-1:0] months_nxt;
  logic [DAY_W-1:0]   days_nxt;

  logic               out_valid_r;
  logic [YEAR_W-1:0]  years_r;
  logic [MONTH_W-1:0] months_r;
  logic [DAY_W-1:0]   days_r;

  assign busy = ~rst_n;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
    a_year_r  <= in_first_year;
    a_month_r <= in_first_month;
    a_day_r   <= in_first_day;
    b_year_r  <= in_second_year;
    b_month_r <= in_second_month;
    b_day_r   <= in_second_day;
  end

  // date cleanup
  cdd_clean u_clean_a (
    .year  (a_year_r),
    .month (a_month_r),
    .day   (a_day_r),
    .date  (date_a)
  );

  cdd_clean u_clean_b (
    .year  (b_year_r),
    .month (b_month_r),
    .day   (b_day_r),
    .date  (date_b)
  );

  // difference
  cdd_diff u_diff (
    .date_a (date_a),
    .date_b (date_b),
    .years  (years_nxt),
    .months (months_nxt),
    .days   (days_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
    years_r  <= years_nxt;
    months_r <= months_nxt;
    days_r   <= days_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_elapsed_years  = years_r;
  assign out_elapsed_months = months_r;
  assign out_elapsed_days   = days_r;

endmodule

`default_nettype wire

// File: src/cdd_checker.sv
`default_nettype none

`include "calendar_date_difference_macros.svh"

module cdd_checker
  import cdd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [YEAR_W-1:0]  in_first_year,
  input wire logic [MONTH_W-1:0] in_first_month,
  input wire logic [DAY_W-1:0]   in_first_day,
  input wire logic [YEAR_W-1:0]  in_second_year,
  input wire logic [MONTH_W-1:0] in_second_month,
  input wire logic [DAY_W-1:0]   in_second_day,
  input wire logic               out_valid,
  input wire logic [YEAR_W-1:0]  out_elapsed_years,
  input wire logic [MONTH_W-1:0] out_elapsed_months,
  input wire logic [DAY_W-1:0]   out_elapsed_days
);

  logic accept;
  logic same_date;
  logic out_zero;

  assign accept    = start && !busy;
  assign same_date = (in_first_year == in_second_year) &&
                     (in_first_month == in_second_month) &&
                     (in_first_day == in_second_day);
  assign out_zero  = (out_elapsed_years == 14'd0) && (out_elapsed_months == 4'd0) &&
                     (out_elapsed_days == 5'd0);

  // every accepted word yields a strobe after the input and result registers
  `CDD_ASSERT_NEXT(a_word_gives_result, accept, ##1 out_valid)

  // no strobe without an accepted word
  `CDD_ASSERT_IMP(a_result_has_word, out_valid, $past(accept, 2))

  // equal dates give all zeros
  `CDD_ASSERT_IMP(a_equal_dates_zero, out_valid && $past(same_date, 2), out_zero)

  // months and days stay below a year and a month
  `CDD_ASSERT_IMP(a_result_range, out_valid, out_elapsed_months <= 4'd11 && out_elapsed_days <= 5'd30)

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (.*);

`default_nettype wire

// File: verif/date_span_checker.sv
module date_span_checker
  import cdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [YEAR_W-1:0]  in_first_year,
  input  logic [MONTH_W-1:0] in_first_month,
  input  logic [DAY_W-1:0]   in_first_day,
  input  logic [YEAR_W-1:0]  in_second_year,
  input  logic [MONTH_W-1:0] in_second_month,
  input  logic [DAY_W-1:0]   in_second_day,
  input  logic               out_valid,
  input  logic [YEAR_W-1:0]  out_elapsed_years,
  input  logic [MONTH_W-1:0] out_elapsed_months,
  input  logic [DAY_W-1:0]   out_elapsed_days,
  output int                 mismatch_count,
  output int                 spans_pending,
  output int                 spans_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [YEAR_W-1:0]  years;
    logic [MONTH_W-1:0] months;
    logic [DAY_W-1:0]   days;
  } span_t;

  span_t expected_spans[$];
  int    fails_seen = 0;
  int    checked_seen = 0;

  initial begin
    mismatch_count = 0;
    spans_pending  = 0;
    spans_checked  = 0;
  end

  // 4/100/400 rule
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
    if (m == MONTH_FEB)
      return is_leap_year(y) ? DAY_FEB_LEAP : DAY_FEB_SHORT;
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
      return DAY_SHORT_MONTH;
    return DAY_LONG_MONTH;
  endfunction

  // pull year, month and day into range, in that order
  function automatic void tidy_date(input int unsigned y_raw, input int unsigned m_raw,
                                    input int unsigned d_raw, output int unsigned y,
                                    output int unsigned m, output int unsigned d);
    y = (y_raw < YEAR_MIN) ? YEAR_MIN : (y_raw > YEAR_MAX) ? YEAR_MAX : y_raw;
    m = (m_raw < MONTH_JAN) ? MONTH_JAN : (m_raw > MONTH_DEC) ? MONTH_DEC : m_raw;
    d = (d_raw < DAY_MIN) ? DAY_MIN : d_raw;
    if (d > days_of_month(y, m))
      d = days_of_month(y, m);
  endfunction

  // whole years, months and leftover days from the earlier date to the later one
  function automatic span_t span_between(input int unsigned ay_raw, input int unsigned am_raw,
                                         input int unsigned ad_raw, input int unsigned by_raw,
                                         input int unsigned bm_raw, input int unsigned bd_raw);
    int unsigned ay, am, ad, by, bm, bd;
    int unsigned ey, em, ed, ly, lm, ld;
    int unsigned anchor, years, months, days, prev_m, prev_len;
    span_t s;
    tidy_date(ay_raw, am_raw, ad_raw, ay, am, ad);
    tidy_date(by_raw, bm_raw, bd_raw, by, bm, bd);
    if ({ay, am, ad} > {by, bm, bd}) begin
      {ey, em, ed} = {by, bm, bd};
      {ly, lm, ld} = {ay, am, ad};
    end else begin
      {ey, em, ed} = {ay, am, ad};
      {ly, lm, ld} = {by, bm, bd};
    end
    // leap day start falls back to feb 28 in a common end year
    anchor = ed;
    if (em == MONTH_FEB && ed == DAY_FEB_LEAP && !is_leap_year(ly))
      anchor = DAY_FEB_SHORT;
    years = ly - ey;
    if (lm < em || (lm == em && ld < anchor)) begin
      years  = years - 1;
      months = lm + MONTH_DEC - em;
    end else begin
      months = lm - em;
    end
    // borrow a month: count from the clamped anchor in the month before the end
    if (ld < anchor) begin
      prev_m   = (lm == MONTH_JAN) ? MONTH_DEC : lm - 1;
      prev_len = days_of_month(ly, prev_m);
      months   = months - 1;
      days     = prev_len - ((anchor > prev_len) ? prev_len : anchor) + ld;
    end else begin
      days = ld - anchor;
    end
    s.years  = years[YEAR_W-1:0];
    s.months = months[MONTH_W-1:0];
    s.days   = days[DAY_W-1:0];
    return s;
  endfunction

  // compare result words first, then record the new pair taken at this edge
  always @(posedge clk) begin : watch
    span_t want;
    if (rst_n && out_valid) begin
      if (expected_spans.size() == 0) begin
        fails_seen++;
        $display("%0t: result word with nothing expected: years %0d months %0d days %0d",
                 $time, out_elapsed_years, out_elapsed_months, out_elapsed_days);
      end else begin
        want = expected_spans.pop_front();
        checked_seen++;
        if (out_elapsed_years !== want.years) begin
          fails_seen++;
          $display("%0t: elapsed_years expected %0d actual %0d",
                   $time, want.years, out_elapsed_years);
        end
        if (out_elapsed_months !== want.months) begin
          fails_seen++;
          $display("%0t: elapsed_months expected %0d actual %0d",
                   $time, want.months, out_elapsed_months);
        end
        if (out_elapsed_days !== want.days) begin
          fails_seen++;
          $display("%0t: elapsed_days expected %0d actual %0d",
                   $time, want.days, out_elapsed_days);
        end
      end
    end
    if (rst_n && start && !busy)
      expected_spans.push_back(span_between(in_first_year, in_first_month, in_first_day,
                                            in_second_year, in_second_month, in_second_day));
    mismatch_count <= fails_seen;
    spans_checked  <= checked_seen;
    spans_pending  <= expected_spans.size();
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [YEAR_W-1:0]  in_first_year = '0;
  logic [MONTH_W-1:0] in_first_month = '0;
  logic [DAY_W-1:0]   in_first_day = '0;
  logic [YEAR_W-1:0]  in_second_year = '0;
  logic [MONTH_W-1:0] in_second_month = '0;
  logic [DAY_W-1:0]   in_second_day = '0;
  logic               out_valid;
  logic [YEAR_W-1:0]  out_elapsed_years;
  logic [MONTH_W-1:0] out_elapsed_months;
  logic [DAY_W-1:0]   out_elapsed_days;

  int mismatch_count, spans_pending, spans_checked;
  int idle_pct = 0;
  int words_sent = 0;
  int directed_words = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  calendar_date_difference dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_first_year      (in_first_year),
    .in_first_month     (in_first_month),
    .in_first_day       (in_first_day),
    .in_second_year     (in_second_year),
    .in_second_month    (in_second_month),
    .in_second_day      (in_second_day),
    .out_valid          (out_valid),
    .out_elapsed_years  (out_elapsed_years),
    .out_elapsed_months (out_elapsed_months),
    .out_elapsed_days   (out_elapsed_days)
  );

  date_span_checker span_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_first_year      (in_first_year),
    .in_first_month     (in_first_month),
    .in_first_day       (in_first_day),
    .in_second_year     (in_second_year),
    .in_second_month    (in_second_month),
    .in_second_day      (in_second_day),
    .out_valid          (out_valid),
    .out_elapsed_years  (out_elapsed_years),
    .out_elapsed_months (out_elapsed_months),
    .out_elapsed_days   (out_elapsed_days),
    .mismatch_count     (mismatch_count),
    .spans_pending      (spans_pending),
    .spans_checked      (spans_checked)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // random idle cycles, then hold the word until the block takes it
  task automatic send_dates(input int unsigned fy, input int unsigned fm, input int unsigned fd,
                            input int unsigned sy, input int unsigned sm, input int unsigned sd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_first_year   <= fy[YEAR_W-1:0];
    in_first_month  <= fm[MONTH_W-1:0];
    in_first_day    <= fd[DAY_W-1:0];
    in_second_year  <= sy[YEAR_W-1:0];
    in_second_month <= sm[MONTH_W-1:0];
    in_second_day   <= sd[DAY_W-1:0];
    @(posedge clk);
    while (busy)
      @(posedge clk);
    words_sent++;
  endtask

  // stop sending until every expected word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (spans_pending != 0)
      @(posedge clk);
  endtask

  // mostly ordinary days, a quarter near the end of a month
  function automatic int unsigned day_guess();
    return ($urandom_range(3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
  endfunction

  task automatic send_random_pair();
    int y1, y2;
    int unsigned m1, m2, d1, d2;
    case ($urandom_range(9))
      // raw bits, out of range fields included
      0: begin
        y1 = $urandom_range(16383);
        y2 = $urandom_range(16383);
        m1 = $urandom_range(15);
        m2 = $urandom_range(15);
        d1 = $urandom_range(31);
        d2 = $urandom_range(31);
      end
      // leap day and century years
      1, 2: begin
        y1 = $urandom_range(1, 99) * 100 + 4 * $urandom_range(0, 1);
        y2 = y1 + $urandom_range(0, 8) - 4;
        m1 = ($urandom_range(1) == 0) ? MONTH_FEB : $urandom_range(1, 12);
        m2 = $urandom_range(1, 3);
        d1 = ($urandom_range(1) == 0) ? DAY_FEB_LEAP : day_guess();
        d2 = day_guess();
      end
      default: begin
        y1 = $urandom_range(1, 9999);
        y2 = ($urandom_range(3) == 0) ? $urandom_range(1, 9999) : y1 + 2 - $urandom_range(4);
        if (y2 < 1)
          y2 = 1;
        m1 = $urandom_range(1, 12);
        m2 = $urandom_range(1, 12);
        d1 = day_guess();
        d2 = day_guess();
      end
    endcase
    if ($urandom_range(1) == 0)
      send_dates(y1, m1, d1, y2, m2, d2);
    else
      send_dates(y2, m2, d2, y1, m1, d1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    idle_pct = 18;
    send_dates(2000, MONTH_JAN, 1, 2000, MONTH_JAN, 1);
    send_dates(1, MONTH_JAN, 1, 9999, MONTH_DEC, 31);
    send_dates(9999, MONTH_DEC, 31, 1, MONTH_JAN, 1);
    send_dates(0, 0, 0, 16383, 15, 31);
    send_dates(16383, 15, 31, 16383, 15, 31);
    send_dates(2001, MONTH_FEB, 31, 2001, 3, 0);
    send_dates(2000, MONTH_FEB, 29, 2001, MONTH_FEB, 28);
    send_dates(2000, MONTH_FEB, 29, 2004, MONTH_FEB, 29);
    send_dates(2000, MONTH_FEB, 29, 2001, 3, 1);
    send_dates(2000, MONTH_FEB, 29, 2100, MONTH_FEB, 28);
    send_dates(2400, MONTH_FEB, 29, 2401, 3, 1);
    send_dates(1900, MONTH_FEB, 29, 1904, MONTH_FEB, 29);
    send_dates(2001, MONTH_JAN, 31, 2001, 3, 1);
    send_dates(2000, MONTH_JAN, 31, 2000, 3, 1);
    send_dates(2003, MONTH_DEC, 31, 2004, MONTH_JAN, 1);
    send_dates(2003, 3, 31, 2003, 5, 1);
    send_dates(2003, 5, 31, 2003, MONTH_JUN, 30);
    send_dates(1999, 7, 20, 1999, 7, 5);
    send_dates(1999, 7, 5, 1999, 7, 20);
    send_dates(1, MONTH_DEC, 31, 2, MONTH_JAN, 1);
    send_dates(9998, MONTH_JAN, 1, 9999, MONTH_JAN, 1);
    send_dates(1582, 10, 15, 1582, 10, 4);
    directed_words = words_sent;
    drain();

    // random words under three idle mixes, drained between them
    idle_pct = 18;
    repeat (WORDS_PER_PHASE) send_random_pair();
    drain();
    idle_pct = 46;
    repeat (WORDS_PER_PHASE) send_random_pair();
    drain();
    idle_pct = 0;
    repeat (WORDS_PER_PHASE) send_random_pair();
    drain();

    repeat (8) @(posedge clk);
    $display("date pairs sent: %0d (%0d directed), results checked: %0d",
             words_sent, directed_words, spans_checked);
    $display("covered leap day starts, month end clamps, swapped order and out of range fields");
    if (mismatch_count == 0 && spans_pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
